// ===== rtl/line_segment_table_macros.svh =====
// Assertion macros shared by the line segment table RTL.
`ifndef LINE_SEGMENT_TABLE_MACROS_SVH
`define LINE_SEGMENT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line_segment_table: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line_segment_table: check failed");

`endif

// ===== rtl/lst_pkg.sv =====
// Types and constants of the line segment table.
package lst_pkg;

	localparam int FIELD_W     = 16;
	localparam int MAX_RESULTS = 16;
	localparam int HIT_CNT_W   = 5;
	// region bounds: signed coordinate plus unsigned extent, no wrap
	localparam int RGN_W       = 18;

	typedef logic [2:0] op_t;

	localparam op_t OP_APPEND = 3'd0;
	localparam op_t OP_REMOVE = 3'd1;
	localparam op_t OP_HAS    = 3'd2;
	localparam op_t OP_POINT  = 3'd3;
	localparam op_t OP_REGION = 3'd4;

	// steps of the shared multiplier for the point-on-segment test
	typedef enum logic [6:0] {
		M_CYDX = 7'b0000001,
		M_CXDY = 7'b0000010,
		M_CXDX = 7'b0000100,
		M_CYDY = 7'b0001000,
		M_DXDX = 7'b0010000,
		M_DYDY = 7'b0100000,
		M_LEN  = 7'b1000000
	} mul_step_t;

endpackage

// ===== rtl/lst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/line_segment_table.sv =====
// Line segment table: append, remove, has, point query and region query.
// Remove and region query scan every stored entry; has stops at the first equal entry.
// A point query takes, per entry, a RAM read, setup and seven steps of one multiplier. A
// query stops at the entry of its sixteenth hit. A new operation is taken only once busy
// drops, which happens as the last result goes out; the receiver cannot stall. Reset
// empties the table.
`include "line_segment_table_macros.svh"

module line_segment_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int COORD_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  lst_pkg::op_t                        operation,
	input  logic signed [lst_pkg::FIELD_W-1:0]  seg_ax,
	input  logic signed [lst_pkg::FIELD_W-1:0]  seg_ay,
	input  logic signed [lst_pkg::FIELD_W-1:0]  seg_bx,
	input  logic signed [lst_pkg::FIELD_W-1:0]  seg_by,
	input  logic signed [lst_pkg::FIELD_W-1:0]  point_x,
	input  logic signed [lst_pkg::FIELD_W-1:0]  point_y,
	input  logic [lst_pkg::FIELD_W-1:0]         region_width,
	input  logic [lst_pkg::FIELD_W-1:0]         region_height,
	output logic                                strobe,
	output logic                                status,
	output logic                                answer_flag,
	output logic                                hit_valid,
	output logic signed [lst_pkg::FIELD_W-1:0]  hit_ax,
	output logic signed [lst_pkg::FIELD_W-1:0]  hit_ay,
	output logic signed [lst_pkg::FIELD_W-1:0]  hit_bx,
	output logic signed [lst_pkg::FIELD_W-1:0]  hit_by,
	output logic                                last
);

	import lst_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_W = 4 * COORD_BITS;
	localparam int DIF_W  = COORD_BITS + 1;
	localparam int PRD_W  = 2 * DIF_W;
	localparam int SUM_W  = PRD_W + 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_EVAL = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_SHR  = 7'b0010000,
		S_SHW  = 7'b0100000,
		S_END  = 7'b1000000
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [WORD_W-1:0]       word_q;
	logic signed [C-1:0]     px_q, py_q;
	logic signed [RGN_W-1:0] x1_q, y1_q;
	logic [CNT_W-1:0]        count_q, idx_q, idx_m1;
	mul_step_t               step_q, step_nxt;
	logic [HIT_CNT_W-1:0]    hits_q;
	logic                    pend_valid_q;
	logic [WORD_W-1:0]       pend_q;
	logic                    flag_q, remain_q, status_q;

	logic                    out_strobe_q, out_status_q, out_flag_q, out_hit_q, out_last_q;
	logic [WORD_W-1:0]       out_word_q;

	logic signed [DIF_W-1:0] dx_q, dy_q, cx_q, cy_q;
	logic signed [DIF_W-1:0] mul_a, mul_b;
	logic signed [PRD_W-1:0] mul_p, prod_q, t_q;
	logic signed [SUM_W-1:0] dot_q, len2;
	logic                    cross_ok_q;

	logic                    ram_we, ram_re;
	logic [IDX_W-1:0]        ram_waddr, ram_raddr;
	logic [WORD_W-1:0]       ram_wdata, ram_rdata;

	logic signed [C-1:0]     e_ax, e_ay, e_bx, e_by;
	logic signed [RGN_W-1:0] r_ax, r_ay, r_bx, r_by, r_px, r_py;
	logic                    ent_eq, region_hit, point_hit, entry_done, hit_now;

	lst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign idx_m1 = idx_q - CNT_W'(1);

	// unpack the entry read from the table
	assign e_ax = signed'(ram_rdata[0*C +: C]);
	assign e_ay = signed'(ram_rdata[1*C +: C]);
	assign e_bx = signed'(ram_rdata[2*C +: C]);
	assign e_by = signed'(ram_rdata[3*C +: C]);

	assign ent_eq = (ram_rdata == word_q);

	assign r_ax = RGN_W'(e_ax);
	assign r_ay = RGN_W'(e_ay);
	assign r_bx = RGN_W'(e_bx);
	assign r_by = RGN_W'(e_by);
	assign r_px = RGN_W'(px_q);
	assign r_py = RGN_W'(py_q);

	assign region_hit = (r_ax >= r_px && r_ax <= x1_q && r_ay >= r_py && r_ay <= y1_q)
		|| (r_bx >= r_px && r_bx <= x1_q && r_by >= r_py && r_by <= y1_q);

	assign len2      = SUM_W'(t_q) + SUM_W'(prod_q);
	assign point_hit = cross_ok_q && !dot_q[SUM_W-1] && (dot_q <= len2);

	assign entry_done = (state_q == S_EVAL && op_q == OP_REGION)
		|| (state_q == S_MUL && step_q == M_LEN);
	assign hit_now = (state_q == S_EVAL && op_q == OP_REGION && region_hit)
		|| (state_q == S_MUL && step_q == M_LEN && point_hit);

	// operand select for the shared multiplier
	always_comb begin
		mul_a    = cy_q;
		mul_b    = dx_q;
		step_nxt = M_CYDX;
		unique case (step_q)
			M_CYDX: begin mul_a = cy_q; mul_b = dx_q; step_nxt = M_CXDY; end
			M_CXDY: begin mul_a = cx_q; mul_b = dy_q; step_nxt = M_CXDX; end
			M_CXDX: begin mul_a = cx_q; mul_b = dx_q; step_nxt = M_CYDY; end
			M_CYDY: begin mul_a = cy_q; mul_b = dy_q; step_nxt = M_DXDX; end
			M_DXDX: begin mul_a = dx_q; mul_b = dx_q; step_nxt = M_DYDY; end
			M_DYDY: begin mul_a = dy_q; mul_b = dy_q; step_nxt = M_LEN;  end
			M_LEN:  begin mul_a = dy_q; mul_b = dy_q; step_nxt = M_CYDX; end
			default: begin mul_a = cy_q; mul_b = dx_q; step_nxt = M_CYDX; end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = word_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_RD: begin
				if (op_q == OP_APPEND) begin
					ram_we = (count_q < CNT_W'(TABLE_DEPTH));
				end else begin
					ram_re = (idx_q < count_q);
				end
			end
			S_SHR: begin
				ram_re = (idx_q < count_q);
			end
			S_SHW: begin
				ram_we    = 1'b1;
				ram_waddr = idx_m1[IDX_W-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
				ram_re = 1'b0;
			end
		endcase
	end

	// arithmetic datapath: differences, products, partial sums
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == S_EVAL) begin
			dx_q <= DIF_W'(e_bx) - DIF_W'(e_ax);
			dy_q <= DIF_W'(e_by) - DIF_W'(e_ay);
			cx_q <= DIF_W'(px_q) - DIF_W'(e_ax);
			cy_q <= DIF_W'(py_q) - DIF_W'(e_ay);
		end
		if (state_q == S_MUL) begin
			unique case (step_q)
				M_CXDY: t_q <= prod_q;
				M_CXDX: cross_ok_q <= (t_q == prod_q);
				M_CYDY: t_q <= prod_q;
				M_DXDX: dot_q <= SUM_W'(t_q) + SUM_W'(prod_q);
				M_DYDY: t_q <= prod_q;
				default: begin end
			endcase
		end
	end

	// sequencer and result words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			step_q       <= M_CYDX;
			hits_q       <= '0;
			pend_valid_q <= 1'b0;
			flag_q       <= 1'b0;
			remain_q     <= 1'b0;
			status_q     <= 1'b0;
			out_strobe_q <= 1'b0;
			out_status_q <= 1'b0;
			out_flag_q   <= 1'b0;
			out_hit_q    <= 1'b0;
			out_last_q   <= 1'b0;
			out_word_q   <= '0;
		end else begin
			out_strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q         <= operation;
						word_q       <= {seg_by[C-1:0], seg_bx[C-1:0],
						                 seg_ay[C-1:0], seg_ax[C-1:0]};
						px_q         <= signed'(point_x[C-1:0]);
						py_q         <= signed'(point_y[C-1:0]);
						x1_q         <= RGN_W'(signed'(point_x[C-1:0])) + RGN_W'(region_width);
						y1_q         <= RGN_W'(signed'(point_y[C-1:0])) + RGN_W'(region_height);
						idx_q        <= '0;
						hits_q       <= '0;
						pend_valid_q <= 1'b0;
						flag_q       <= 1'b0;
						remain_q     <= 1'b0;
						status_q     <= 1'b0;
						if (operation == OP_APPEND || operation == OP_REMOVE
							|| operation == OP_HAS || operation == OP_POINT
							|| operation == OP_REGION) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_END;
						end
					end
				end
				S_RD: begin
					if (op_q == OP_APPEND) begin
						if (count_q < CNT_W'(TABLE_DEPTH)) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							status_q <= 1'b1;
						end
						state_q <= S_END;
					end else if (idx_q < count_q) begin
						state_q <= S_EVAL;
					end else begin
						// no equal entry: remove reports nothing left
						if (op_q == OP_REMOVE) begin
							flag_q <= 1'b1;
						end
						state_q <= S_END;
					end
				end
				S_EVAL: begin
					if (op_q == OP_HAS) begin
						if (ent_eq) begin
							flag_q  <= 1'b1;
							state_q <= S_END;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_RD;
						end
					end else if (op_q == OP_REMOVE) begin
						idx_q <= idx_q + CNT_W'(1);
						state_q <= ent_eq ? S_SHR : S_RD;
					end else if (op_q == OP_POINT) begin
						step_q  <= M_CYDX;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_nxt;
				end
				S_SHR: begin
					if (idx_q < count_q) begin
						state_q <= S_SHW;
					end else begin
						count_q <= count_q - CNT_W'(1);
						flag_q  <= !remain_q;
						state_q <= S_END;
					end
				end
				S_SHW: begin
					// watch for a further equal copy while moving entries down
					if (ent_eq) begin
						remain_q <= 1'b1;
					end
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= S_SHR;
				end
				S_END: begin
					out_strobe_q <= 1'b1;
					out_status_q <= status_q;
					out_flag_q   <= flag_q;
					out_hit_q    <= pend_valid_q;
					out_word_q   <= pend_valid_q ? pend_q : '0;
					out_last_q   <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// hold each hit until the next one shows whether it is the final word
			if (entry_done) begin
				if (hit_now) begin
					if (pend_valid_q) begin
						out_strobe_q <= 1'b1;
						out_status_q <= 1'b0;
						out_flag_q   <= 1'b0;
						out_hit_q    <= 1'b1;
						out_word_q   <= pend_q;
						out_last_q   <= 1'b0;
					end
					pend_q       <= ram_rdata;
					pend_valid_q <= 1'b1;
					hits_q       <= hits_q + HIT_CNT_W'(1);
					if (hits_q == HIT_CNT_W'(MAX_RESULTS - 1)) begin
						state_q <= S_END;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_RD;
					end
				end else begin
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= S_RD;
				end
			end
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign strobe      = out_strobe_q;
	assign status      = out_status_q;
	assign answer_flag = out_flag_q;
	assign hit_valid   = out_hit_q;
	assign last        = out_last_q;
	assign hit_ax      = FIELD_W'($signed(out_word_q[0*C +: C]));
	assign hit_ay      = FIELD_W'($signed(out_word_q[1*C +: C]));
	assign hit_bx      = FIELD_W'($signed(out_word_q[2*C +: C]));
	assign hit_by      = FIELD_W'($signed(out_word_q[3*C +: C]));

	`LST_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`LST_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`LST_ASSERT_NOW(a_last_idle, out_strobe_q && out_last_q, !busy)
	`LST_ASSERT_NOW(a_hit_clean, out_strobe_q && out_hit_q, !out_status_q && !out_flag_q)
	`LST_ASSERT_NOW(a_mid_is_hit, out_strobe_q && !out_last_q, out_hit_q)

endmodule
